### src/ils_pkg.sv
// Shared types and codes for the indexed list store.
// No dependencies; imported by the top level.
package ils_pkg;

  typedef logic [2:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FUNC_READ = 3'd0;
  localparam func_t FUNC_HEAD = 3'd1;
  localparam func_t FUNC_TAIL = 3'd2;
  localparam func_t FUNC_AT   = 3'd3;
  localparam func_t FUNC_DEL  = 3'd4;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_RANGE = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam int ValueWidth = 32;
  localparam int PosWidth   = 9;
  localparam logic signed [ValueWidth-1:0] ReadFail = -32'sd1;

endpackage

### src/indexed_list_store_unit.sv
// Indexed list store top level: an ordered list of signed 32-bit values in one RAM.
// Depends on ils_pkg and ils_ram.
//
// Element i of the list always sits in RAM entry i, so a read is one RAM access,
// while an insert or delete shifts every later element by one entry, one entry
// per cycle through the single write port of the RAM. One request is in flight
// at a time. A read passes through S_RD to S_DONE; an insert at the tail, an
// append at index count or any refused request goes straight to S_DONE; an
// insert at index p (head is p = 0) walks S_UP from the last element down to p,
// then S_PLACE; a delete below the last element walks S_DN. The result sits in
// an output register, so a new request is taken while the previous result is
// still stalled; the block holds a finished result internally only if that
// register is still full. Stored values need no reset: only entries below the
// element count are ever read, and each of them has been written.
module indexed_list_store_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ils_pkg::func_t                       func_i,
  input  logic [ils_pkg::PosWidth-1:0]         position_i,
  input  logic signed [ils_pkg::ValueWidth-1:0] item_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ils_pkg::ValueWidth-1:0] read_value_o,
  output ils_pkg::status_t                     status_o,
  output logic [ils_pkg::PosWidth-1:0]         count_after_o
);

  import ils_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PosWidth) ? CW : PosWidth;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_DN    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] at_q, at_d;
  logic [AW-1:0] end_q, end_d;
  logic signed [ValueWidth-1:0] value_q, value_d;
  logic signed [ValueWidth-1:0] res_value_q, res_value_d;
  status_t res_status_q, res_status_d;
  logic [PosWidth-1:0] res_count_q, res_count_d;
  logic out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0] out_value_q, out_value_d;
  status_t out_status_q, out_status_d;
  logic [PosWidth-1:0] out_count_q, out_count_d;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ValueWidth-1:0] ram_wdata, ram_rdata;

  logic [CMPW-1:0] pos_w, cnt_w;
  logic [AW-1:0] pos_a, cnt_a, last_a;
  logic full;
  logic out_free;

  assign pos_w  = CMPW'(position_i);
  assign cnt_w  = CMPW'(count_q);
  assign pos_a  = pos_w[AW-1:0];
  assign cnt_a  = cnt_w[AW-1:0];
  assign last_a = cnt_a - AW'(1);
  assign full   = (cnt_w == CMPW'(CAPACITY));
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    at_d         = at_q;
    end_d        = end_q;
    value_d      = value_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // Decide the outcome now; the walk below only moves data.
          res_value_d  = ReadFail;
          res_status_d = STATUS_RANGE;
          value_d      = item_value_i;
          state_d      = S_DONE;
          case (func_i)
            FUNC_READ: begin
              if (pos_w < cnt_w) begin
                res_status_d = STATUS_DONE;
                ram_re       = 1'b1;
                ram_raddr    = pos_a;
                state_d      = S_RD;
              end
            end
            FUNC_HEAD, FUNC_TAIL, FUNC_AT: begin
              if (func_i == FUNC_AT && pos_w > cnt_w) begin
                res_status_d = STATUS_RANGE;
              end else if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                res_status_d = STATUS_DONE;
                count_d      = count_q + CW'(1);
                if (func_i == FUNC_HEAD) begin
                  at_d = '0;
                end else if (func_i == FUNC_TAIL) begin
                  at_d = cnt_a;
                end else begin
                  at_d = pos_a;
                end
                if (func_i == FUNC_TAIL || cnt_w == '0 ||
                    (func_i == FUNC_AT && pos_w == cnt_w)) begin
                  // Append, or insert into an empty list: no shift needed.
                  ram_we    = 1'b1;
                  ram_waddr = cnt_a;
                  ram_wdata = item_value_i;
                end else begin
                  // Open a gap: walk from the last element down.
                  ram_re    = 1'b1;
                  ram_raddr = last_a;
                  ptr_d     = last_a;
                  state_d   = S_UP;
                end
              end
            end
            FUNC_DEL: begin
              if (pos_w < cnt_w) begin
                res_status_d = STATUS_DONE;
                count_d      = count_q - CW'(1);
                if (pos_a != last_a) begin
                  ram_re    = 1'b1;
                  ram_raddr = pos_a + AW'(1);
                  ptr_d     = pos_a + AW'(1);
                  end_d     = last_a;
                  state_d   = S_DN;
                end
              end
            end
            default: begin
              res_status_d = STATUS_RANGE;
            end
          endcase
          res_count_d = PosWidth'(count_d);
        end
      end
      S_RD: begin
        res_value_d = ram_rdata;
        state_d     = S_DONE;
      end
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == at_q) begin
          state_d = S_PLACE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = at_q;
        ram_wdata = value_q;
        state_d   = S_DONE;
      end
      S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == end_q) begin
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_count_d  = res_count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    at_q         <= at_d;
    end_q        <= end_d;
    value_q      <= value_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  ils_ram #(
    .Width (ValueWidth),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign status_o      = out_status_q;
  assign count_after_o = out_count_q;

endmodule

### src/ils_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ils_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
